FILE: sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 message digest.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned NumRounds = 64;

    typedef logic [31:0] t_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;   // write one byte into the block buffer
        logic [7:0] byte_val;
        logic       count_len;   // add eight to the bit-length count
        logic       start_comp;  // begin compressing the full buffer
        logic       reinit;      // restore the initial chain and clear counts
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic        busy;       // compression in progress
        logic [5:0]  count;      // bytes buffered in the current block
        logic [63:0] bit_len;    // bits of message taken so far
    } t_dp_status;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_h(input logic [2:0] idx);
        t_word h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

endpackage

FILE: sv/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, bit-length count, chain words and the one-round-per-cycle
// compression unit with its rolling 16-word message schedule.
// ----------------------------------------------------------------------------
module sha_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_dp_cmd    i_cmd,
    output sha_pkg::t_dp_status o_status,
    output logic [255:0]        o_chain
);
    import sha_pkg::*;

    // The block is kept as sixteen big-endian words; each byte lands in its lane.
    t_word       r_block [16];
    t_word       r_sched [16];
    t_word       r_chain [8];
    t_word       r_v     [8];
    logic [5:0]  r_count;
    logic [63:0] r_bit_len;
    logic        r_busy;
    logic        r_fold;
    logic [5:0]  r_round;

    t_word w_cur, w_new, t1, t2, x15, x2, s0, s1;

    always_comb begin
        x15 = r_sched[1];
        x2  = r_sched[14];
        s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        w_new = r_sched[0] + s0 + r_sched[9] + s1;
        // Slot 0 holds the word for rounds 0-15; later rounds use w_new.
        w_cur = (r_round < 6'd16) ? r_sched[0] : w_new;
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_round) + w_cur;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_block[r_count[5:2]][31 - 8*r_count[1:0] -: 8] <= i_cmd.byte_val;
        end
        if (i_cmd.start_comp) begin
            for (int i = 0; i < 16; i++) begin
                r_sched[i] <= r_block[i];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_sched[i] <= r_sched[i+1];
            end
            r_sched[15] <= w_cur;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_count   <= '0;
            r_bit_len <= '0;
            r_busy    <= 1'b0;
            r_fold    <= 1'b0;
            r_round   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_h(3'(i));
            end
        end else begin
            r_fold <= 1'b0;
            if (i_cmd.load_byte) begin
                r_count <= r_count + 6'd1;
            end
            if (i_cmd.count_len) begin
                r_bit_len <= r_bit_len + 64'd8;
            end
            if (i_cmd.start_comp) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'(NumRounds - 1)) begin
                    r_busy <= 1'b0;
                    r_fold <= 1'b1;
                end
            end
            if (r_fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end
        end
    end

    always_comb begin
        o_status.busy    = r_busy | r_fold;
        o_status.count   = r_count;
        o_status.bit_len = r_bit_len;
        for (int i = 0; i < 8; i++) begin
            o_chain[255-32*i -: 32] = r_chain[i];
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_comp |-> !r_busy)
        else $error("compression started while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.load_byte)
        else $error("byte loaded during compression");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fold |-> !r_busy)
        else $error("fold overlaps rounds");
endmodule

FILE: sv/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: feeds message bytes, padding and length into the datapath,
// starts compressions and hands the digest out in four beats.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [31:0]         i_data_word,
    input  logic [2:0]          i_valid_bytes,
    input  logic                i_is_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_part_index,
    output sha_pkg::t_dp_cmd    o_cmd,
    input  sha_pkg::t_dp_status i_status
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_BYTES, S_PAD, S_LEN, S_COMP, S_OUT
    } t_state;

    t_state      r_state, r_ret;
    logic [31:0] r_word;
    logic [2:0]  r_nbytes;
    logic [1:0]  r_bidx;
    logic        r_last;
    logic [2:0]  r_lidx;
    logic [63:0] r_len;
    logic [1:0]  r_part;
    logic        r_started;
    logic        r_padded;
    logic [2:0]  cnt_in;
    logic        full_next;

    assign cnt_in    = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
    assign full_next = (i_status.count == 6'd63);

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_BYTES: begin
                o_cmd.load_byte = 1'b1;
                o_cmd.count_len = 1'b1;
                o_cmd.byte_val  = r_word[31 - 8*r_bidx -: 8];
            end
            S_PAD: begin
                o_cmd.load_byte = 1'b1;
                o_cmd.byte_val  = r_started ? 8'h00 : PadByte;
            end
            S_LEN: begin
                o_cmd.load_byte = 1'b1;
                o_cmd.byte_val  = r_len[63 - 8*r_lidx -: 8];
            end
            S_COMP:  o_cmd.start_comp = !r_started;
            S_OUT:   o_cmd.reinit = i_out_ready && r_part == 2'd3;
            default: ;
        endcase
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_part_index = r_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_bidx    <= '0;
            r_lidx    <= '0;
            r_part    <= '0;
            r_started <= 1'b0;
            r_padded  <= 1'b0;
            r_last    <= 1'b0;
            r_nbytes  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_word   <= i_data_word;
                    r_nbytes <= cnt_in;
                    r_last   <= i_is_last;
                    r_bidx   <= '0;
                    r_padded <= 1'b0;
                    if (cnt_in != 3'd0) begin
                        r_state <= S_BYTES;
                    end else if (i_is_last) begin
                        r_state   <= S_PAD;
                        r_started <= 1'b0;
                    end
                end
                S_BYTES: begin
                    r_bidx <= r_bidx + 2'd1;
                    priority if ({1'b0, r_bidx} + 3'd1 == r_nbytes) begin
                        r_ret     <= r_last ? S_PAD : S_IDLE;
                        r_state   <= full_next ? S_COMP : (r_last ? S_PAD : S_IDLE);
                        r_started <= 1'b0;
                    end else if (full_next) begin
                        r_ret     <= S_BYTES;
                        r_state   <= S_COMP;
                        r_started <= 1'b0;
                    end
                end
                S_PAD: begin
                    // First pass writes 0x80, later passes write zeros.
                    r_padded <= 1'b1;
                    if (!r_started) begin
                        r_len <= i_status.bit_len;
                    end
                    priority if (full_next) begin
                        r_ret     <= S_PAD;
                        r_state   <= S_COMP;
                        r_started <= 1'b0;
                    end else if (i_status.count + 6'd1 == LenPos) begin
                        r_state   <= S_LEN;
                        r_lidx    <= '0;
                        r_started <= 1'b1;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                S_LEN: begin
                    r_lidx <= r_lidx + 3'd1;
                    if (r_lidx == 3'd7) begin
                        r_ret     <= S_OUT;
                        r_state   <= S_COMP;
                        r_started <= 1'b0;
                        r_part    <= '0;
                    end
                end
                S_COMP: begin
                    if (r_started && !i_status.busy) begin
                        r_state <= r_ret;
                        // Returning to padding after 0x80 went out: zeros only.
                        r_started <= (r_ret == S_PAD) && r_padded;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                S_OUT: if (i_out_ready) begin
                    r_part <= r_part + 2'd1;
                    if (r_part == 2'd3) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(r_part))
        else $error("digest beat dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !i_status.busy)
        else $error("input taken during compression");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.reinit |-> r_part == 2'd3)
        else $error("reinit before final beat");
endmodule

FILE: sv/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 over a byte stream, digest returned as four 64-bit beats.
// ----------------------------------------------------------------------------
// Usage: each input beat carries up to four message bytes in tdata[31:0],
// first byte in bits 31..24, the byte count in tdata[34:32] (values above
// four count as four) and the end-of-message flag on tlast. Bytes are written
// into a 64-byte buffer one per cycle, pausing while a full block is
// compressed, and no new beat is taken until the bytes of the last one are
// all in. Each full block is compressed at one round per cycle: a start
// step, 64 rounds, a fold into the chain words and a return to the step it
// interrupted. On tlast the block appends 0x80, zeros and the 64-bit
// big-endian bit length (one byte per cycle, pausing to compress a full
// block, an extra block when needed), then presents the digest as four
// output beats, most significant quarter first, tuser giving the quarter
// index and tlast marking the fourth.
// A stalled receiver holds the current beat; no new input is taken until the
// digest is fully delivered, after which the state returns to the standard
// initial hash values. Synchronous reset does the same at once.
// ----------------------------------------------------------------------------
module sha256_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], valid_bytes[34:32], zeros
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_part[63:0]
    output logic [1:0]  m_axis_tuser,   // part_index[1:0]
    output logic        m_axis_tlast    // last_part
);
    import sha_pkg::*;

    t_dp_cmd      cmd;
    t_dp_status   status;
    logic [255:0] chain;
    logic [1:0]   part;

    sha_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_data_word   (s_axis_tdata[31:0]),
        .i_valid_bytes (s_axis_tdata[34:32]),
        .i_is_last     (s_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_part_index  (part),
        .o_cmd         (cmd),
        .i_status      (status)
    );

    sha_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .o_chain  (chain)
    );

    assign m_axis_tdata = chain[255 - 64*part -: 64];
    assign m_axis_tuser = part;
    assign m_axis_tlast = (part == 2'd3);
endmodule

FILE: dv/tb_sha256_message_digest.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_message_digest
// Self-checking bench: directed and random messages streamed in beats of
// up to four bytes are hashed by a behavioral SHA-256 in the bench, and the
// four digest beats of each message are compared with the output stream.
// ----------------------------------------------------------------------------
module tb_sha256_message_digest;

    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        is_last;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } t_digest_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // data_word[31:0], valid_bytes[34:32], zeros
    logic        s_axis_tlast = 1'b0; // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;   // digest_part[63:0]
    logic [1:0]  m_axis_tuser;   // part_index[1:0]
    logic        m_axis_tlast;   // last_part

    sha256_message_digest dut (.*);

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] InitChain [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // Bench copy of the hashing state.
    logic [31:0] hash_chain [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] msg_bits;

    t_in_beat     pending_beats [$];
    t_digest_beat expected_digest [$];
    bit           failed = 0;
    bit           all_sent = 0;
    int           hold_off_left = 400;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_msg_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
        for (int i = 0; i < 64; i++) begin
            if (i >= 16) begin
                s0 = ror32(w[(i+1)%16], 7) ^ ror32(w[(i+1)%16], 18) ^ (w[(i+1)%16] >> 3);
                s1 = ror32(w[(i+14)%16], 17) ^ ror32(w[(i+14)%16], 19)
                     ^ (w[(i+14)%16] >> 10);
                w[i%16] = w[i%16] + s0 + w[(i+9)%16] + s1;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i%16];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
    endfunction

    function automatic void append_byte(logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            compress_msg_block();
            block_fill = 0;
        end
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) hash_chain[i] = InitChain[i];
        block_fill = 0;
        msg_bits = '0;
    endfunction

    // Absorbs one accepted beat; on the final beat pads and queues the digest.
    function automatic void absorb_beat(t_in_beat b);
        int unsigned n;
        logic [63:0] len;
        t_digest_beat d;
        n = (b.valid_bytes > 4) ? 4 : b.valid_bytes;
        for (int i = 0; i < n; i++) begin
            append_byte(b.data_word[31-8*i -: 8]);
            msg_bits += 64'd8;
        end
        if (!b.is_last) return;
        len = msg_bits;
        append_byte(8'h80);
        while (block_fill != 56) append_byte(8'h00);
        for (int i = 0; i < 8; i++) append_byte(len[63-8*i -: 8]);
        for (int k = 0; k < 4; k++) begin
            d.digest_part = {hash_chain[2*k], hash_chain[2*k+1]};
            d.part_index  = k[1:0];
            d.last_part   = (k == 3);
            expected_digest.push_back(d);
        end
        restart_message();
    endfunction

    function automatic int gap_len();
        // Mostly short gaps, now and then a long one, sometimes none at all.
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_beat(logic [31:0] w, logic [2:0] n, logic l);
        t_in_beat b;
        b.data_word = w; b.valid_bytes = n; b.is_last = l;
        pending_beats.push_back(b);
    endfunction

    // A message of a given byte length in four-byte beats of random data, the last beat carrying the rest.
    function automatic void queue_message(int unsigned nbytes);
        int unsigned left;
        left = nbytes;
        while (left > 4) begin
            queue_beat($urandom, 3'd4, 1'b0);
            left -= 4;
        end
        queue_beat($urandom, left[2:0], 1'b1);
    endfunction

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Remembers whether the beat on offer was taken at the last rising edge.
    bit in_fire = 0;
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Driver: offers beats from the pending queue with random gaps.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_fire) begin
            // Beat still on offer; hold it.
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            t_in_beat b;
            b = pending_beats.pop_front();
            s_axis_tdata  <= {5'b0, b.valid_bytes, b.data_word};
            s_axis_tlast  <= b.is_last;
            s_axis_tvalid <= 1'b1;
            send_gap <= gap_len();
        end else begin
            s_axis_tvalid <= 1'b0;
            all_sent <= 1'b1;
        end
    end

    // Receiver ready, with its own random stalls and a long hold-off after reset.
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            recv_gap <= gap_len();
        end
    end

    // Monitor: predicts on input acceptance and checks each output beat.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            absorb_beat({s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast});
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_digest.size() == 0) begin
                $error("digest beat with nothing expected: %h", m_axis_tdata);
                failed = 1;
            end else begin
                t_digest_beat e;
                e = expected_digest.pop_front();
                if (m_axis_tdata !== e.digest_part) begin
                    $error("digest_part expected %h actual %h", e.digest_part, m_axis_tdata);
                    failed = 1;
                end
                if (m_axis_tuser !== e.part_index) begin
                    $error("part_index expected %0d actual %0d", e.part_index, m_axis_tuser);
                    failed = 1;
                end
                if (m_axis_tlast !== e.last_part) begin
                    $error("last_part expected %0d actual %0d", e.last_part, m_axis_tlast);
                    failed = 1;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned nb;
        restart_message();
        i_rst_n = 1'b0;

        // Directed: empty message, "abc", over-range byte counts, empty
        // non-final beat, ignored trailing bytes, and the padding edges.
        queue_beat(32'hffffffff, 3'd0, 1'b1);
        queue_beat(32'h616263ff, 3'd3, 1'b1);
        queue_beat(32'hdeadbeef, 3'd7, 1'b0);
        queue_beat(32'h12345678, 3'd0, 1'b0);
        queue_beat(32'h00000000, 3'd5, 1'b0);
        queue_beat(32'hffffffff, 3'd6, 1'b0);
        queue_beat(32'ha5ffffff, 3'd1, 1'b1);
        queue_beat(32'h0000ffff, 3'd2, 1'b1);
        queue_message(55);   // padding fits in the same block
        queue_message(56);   // length forces an extra block
        queue_message(64);   // exactly one full block of data
        // A long message whose padding and length spill into a third block.
        queue_message(120);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Random messages, mostly short, a few spanning several blocks.
        while (pending_beats.size() < 130) begin
            if ($urandom_range(0, 9) == 0) nb = $urandom_range(60, 140);
            else nb = $urandom_range(0, 40);
            if ($urandom_range(0, 7) == 0) queue_beat($urandom, 3'd0, 1'b0);
            queue_message(nb);
        end

        wait (all_sent && pending_beats.size() == 0);
        wait (expected_digest.size() == 0);
        repeat (200) @(posedge i_clk);
        if (!failed && expected_digest.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
